>>> rtl/xed_pkg.sv
// Shared types, character codes and helpers for the XML entity decoder.
// No dependencies; used by xed_front, xed_back and the top level.
package xed_pkg;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // Named entities: text (first char in low byte), length, replacement
  localparam int NUM_NAMES = 5;
  localparam logic [31:0] NAME_STR [NUM_NAMES] = '{
    32'h00706D61,   // amp
    32'h0000746C,   // lt
    32'h00007467,   // gt
    32'h746F7571,   // quot
    32'h736F7061    // apos
  };
  localparam int NAME_LEN [NUM_NAMES] = '{3, 2, 2, 4, 4};
  localparam logic [7:0] NAME_CHAR [NUM_NAMES] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

  typedef enum logic [1:0] {
    CMD_BYTE,     // pass one byte
    CMD_FLUSH,    // '&' then the first len buffered bytes
    CMD_DECIDE    // entity closed by ';'
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        text_end;
    logic [7:0]  data;
  } cmd_ctl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } code_seq_t;

  function automatic digit_t digit_value(input logic [7:0] c, input logic hex);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d.ok  = 1'b1;
      d.val = c[3:0];
    end else if (hex && (c inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
      d.ok  = 1'b1;
      d.val = c[3:0] + 4'd9;
    end
    return d;
  endfunction

  // Code point to UTF-8; zero maps to '?'
  function automatic code_seq_t utf8_encode(input logic [31:0] cp);
    code_seq_t c;
    c.bytes    = '0;
    c.last_idx = 2'd0;
    if (cp == 32'd0) begin
      c.bytes[0] = CH_QMARK;
    end else if (cp < 32'h80) begin
      c.bytes[0] = cp[7:0];
    end else if (cp < 32'h800) begin
      c.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      c.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      c.last_idx = 2'd1;
    end else if (cp < 32'h10000) begin
      c.bytes[0] = 8'hE0 | {4'h0, cp[15:12]};
      c.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      c.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      c.last_idx = 2'd2;
    end else begin
      c.bytes[0] = 8'hF0 | cp[25:18];
      c.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      c.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      c.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      c.last_idx = 2'd3;
    end
    return c;
  endfunction

endpackage

>>> rtl/xml_entity_decoder_utf8.sv
// Channel  Dir  Signals                      Contents (low bit up)
// s_       in   s_tvalid/s_tready/s_tdata    tdata[7:0] text_byte; tlast end_of_text
// m_       out  m_tvalid/m_tready/m_tdata    tdata[7:0] out_byte; tuser run_last;
//                                            tlast text_done
// Plain bytes go through the back end's load-then-emit sequence, one at a time.
// A closed entity is loaded, then scanned byte by byte in the back end, and its
// output bytes are emitted after the scan.
// A timeout with an '&' inside stalls the input while the bytes after it are repacked.
// A two-entry command queue lets the input run while the output is stalled.
// Synchronous reset clears control state only; the entity buffer needs no clearing.
// Depends on xed_pkg, xed_front, xed_queue and xed_back.
module xml_entity_decoder_utf8 #(
  parameter int MAX_ENTITY_SPAN = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // run_last
  output logic       m_tlast
);

  localparam int CW = $clog2(MAX_ENTITY_SPAN + 1);
  localparam int QW = $bits(xed_pkg::cmd_ctl_t) + CW + 8 * MAX_ENTITY_SPAN;

  logic                       q_push;
  logic                       q_space;
  logic                       q_valid;
  logic                       q_pop;
  logic                       back_busy;
  xed_pkg::cmd_ctl_t          f_ctl;
  xed_pkg::cmd_ctl_t          q_ctl;
  logic [CW-1:0]              f_len;
  logic [CW-1:0]              q_len;
  logic [8*MAX_ENTITY_SPAN-1:0] f_bytes;
  logic [8*MAX_ENTITY_SPAN-1:0] q_bytes;
  logic [QW-1:0]              q_in;
  logic [QW-1:0]              q_head;

  xed_front #(.SPAN(MAX_ENTITY_SPAN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd_push  (q_push),
    .cmd_ctl   (f_ctl),
    .cmd_len   (f_len),
    .cmd_bytes (f_bytes),
    .cmd_space (q_space)
  );

  assign q_in = {f_ctl, f_len, f_bytes};

  xed_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .space     (q_space),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  assign {q_ctl, q_len, q_bytes} = q_head;

  xed_back #(.SPAN(MAX_ENTITY_SPAN)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ctl    (q_ctl),
    .q_len    (q_len),
    .q_bytes  (q_bytes),
    .q_pop    (q_pop),
    .busy     (back_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_space)
    else $error("command pushed into a full queue");

  a_back_has_cmd: assert property (@(posedge clk) disable iff (rst)
    back_busy |-> q_valid)
    else $error("back end working without a queued command");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("end of text flagged on a byte that does not close its transaction run");

endmodule

>>> rtl/xed_front.sv
// Front end: accepts text bytes, tracks entity collection and turns each
// transaction into at most one command. Depends on xed_pkg.
module xed_front #(
  parameter int SPAN = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,
  input  logic                          s_tlast,
  output logic                          cmd_push,
  output xed_pkg::cmd_ctl_t             cmd_ctl,
  output logic [$clog2(SPAN+1)-1:0]     cmd_len,
  output logic [8*SPAN-1:0]             cmd_bytes,
  input  logic                          cmd_space
);

  localparam int CW = $clog2(SPAN + 1);
  localparam int IW = $clog2(SPAN);
  localparam logic [IW-1:0] LAST_IDX = IW'(SPAN - 1);

  typedef enum logic [1:0] {
    F_RUN  = 2'b01,
    F_PACK = 2'b10
  } fstate_t;

  fstate_t       state;
  logic          collecting;
  logic [IW-1:0] count;
  logic          amp_seen;
  logic [IW-1:0] amp_first;
  logic [IW-1:0] rd;
  logic [7:0]    ent_buf [SPAN];
  logic [7:0]    buf_in  [SPAN];

  logic          accept;
  logic          is_amp;
  logic          is_semi;
  logic          full_span;
  logic          hit_amp;
  logic [IW-1:0] first;

  assign s_tready  = (state == F_RUN) && cmd_space;
  assign accept    = s_tvalid && s_tready;
  assign is_amp    = s_tdata == xed_pkg::CH_AMP;
  assign is_semi   = s_tdata == xed_pkg::CH_SEMI;
  assign full_span = count == LAST_IDX;
  assign hit_amp   = amp_seen || is_amp;
  assign first     = amp_seen ? amp_first : LAST_IDX;

  // buffer as it stands with this byte appended
  always_comb begin
    for (int i = 0; i < SPAN; i++) buf_in[i] = ent_buf[i];
    if (collecting && !is_semi) buf_in[count] = s_tdata;
    for (int i = 0; i < SPAN; i++) cmd_bytes[i*8 +: 8] = buf_in[i];
  end

  always_comb begin
    cmd_push         = 1'b0;
    cmd_ctl.kind     = xed_pkg::CMD_BYTE;
    cmd_ctl.text_end = s_tlast;
    cmd_ctl.data     = s_tdata;
    cmd_len          = '0;
    if (accept) begin
      if (!collecting) begin
        if (!is_amp) begin
          cmd_push = 1'b1;
        end else if (s_tlast) begin
          cmd_push     = 1'b1;
          cmd_ctl.kind = xed_pkg::CMD_FLUSH;
        end
      end else if (is_semi) begin
        cmd_push     = 1'b1;
        cmd_ctl.kind = xed_pkg::CMD_DECIDE;
        cmd_len      = CW'(count);
      end else if (!full_span) begin
        if (s_tlast) begin
          cmd_push     = 1'b1;
          cmd_ctl.kind = xed_pkg::CMD_FLUSH;
          cmd_len      = CW'(count) + CW'(1);
        end
      end else begin
        // span exhausted: replay up to the first '&' (all bytes at end of text or with no '&')
        cmd_push     = 1'b1;
        cmd_ctl.kind = xed_pkg::CMD_FLUSH;
        cmd_len      = (s_tlast || !hit_amp) ? CW'(SPAN) : CW'(first);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_RUN;
      collecting <= 1'b0;
      count      <= '0;
      amp_seen   <= 1'b0;
    end else begin
      case (state)
        F_RUN: begin
          if (accept) begin
            if (!collecting) begin
              if (is_amp && !s_tlast) begin
                collecting <= 1'b1;
                count      <= '0;
                amp_seen   <= 1'b0;
              end
            end else if (is_semi) begin
              collecting <= 1'b0;
              count      <= '0;
            end else if (!full_span) begin
              if (s_tlast) begin
                collecting <= 1'b0;
                count      <= '0;
              end else begin
                count <= count + IW'(1);
                if (is_amp && !amp_seen) begin
                  amp_seen  <= 1'b1;
                  amp_first <= count;
                end
              end
            end else if (s_tlast || !hit_amp) begin
              collecting <= 1'b0;
              count      <= '0;
            end else begin
              // restart with the bytes after the first '&'
              count    <= '0;
              amp_seen <= 1'b0;
              if (first != LAST_IDX) begin
                state <= F_PACK;
                rd    <= first + IW'(1);
              end
            end
          end
        end
        F_PACK: begin
          count <= count + IW'(1);
          rd    <= rd + IW'(1);
          if (ent_buf[rd] == xed_pkg::CH_AMP && !amp_seen) begin
            amp_seen  <= 1'b1;
            amp_first <= count;
          end
          if (rd == LAST_IDX) state <= F_RUN;
        end
        default: state <= F_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_RUN && accept && collecting && !is_semi) begin
      ent_buf[count] <= s_tdata;
    end else if (state == F_PACK) begin
      ent_buf[count] <= ent_buf[rd];
    end
  end

endmodule

>>> rtl/xed_queue.sv
// Two-entry command queue between front and back end.
// No package dependencies.
module xed_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  output logic             valid,
  output logic [WIDTH-1:0] head,
  input  logic             pop
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign space = fill != 2'd2;
  assign valid = fill != 2'd0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

>>> rtl/xed_back.sv
// Back end: executes queued commands, scans closed entities one byte a
// cycle and drives the output register. Depends on xed_pkg.
module xed_back #(
  parameter int SPAN = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  xed_pkg::cmd_ctl_t             q_ctl,
  input  logic [$clog2(SPAN+1)-1:0]     q_len,
  input  logic [8*SPAN-1:0]             q_bytes,
  output logic                          q_pop,
  output logic                          busy,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);

  localparam int CW = $clog2(SPAN + 1);
  localparam int IW = $clog2(SPAN);
  localparam int NN = xed_pkg::NUM_NAMES;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SCAN = 6'b000010,
    B_LEAD = 6'b000100,
    B_BODY = 6'b001000,
    B_TAIL = 6'b010000,
    B_CODE = 6'b100000
  } bstate_t;

  bstate_t            state;
  logic [CW-1:0]      idx;
  logic [NN-1:0]      name_ok;
  logic               is_hash;
  logic               hex;
  logic               live;
  logic [31:0]        cp;
  xed_pkg::code_seq_t code;
  logic               tail;

  logic [7:0]         q_arr [SPAN];
  logic [7:0]         cur;
  xed_pkg::digit_t    dig;
  logic [35:0]        cp_wide;
  logic [35:0]        acc;
  logic [31:0]        cp_next;
  logic [NN-1:0]      name_hit;
  logic [7:0]         name_byte;
  logic               out_free;
  logic               emit;
  logic               emit_last;
  logic [7:0]         emit_byte;
  logic               body_end;
  logic               load;
  logic               scan_step;
  logic               scan_done;
  logic               to_code;

  always_comb begin
    for (int i = 0; i < SPAN; i++) q_arr[i] = q_bytes[i*8 +: 8];
  end

  assign cur      = q_arr[idx[IW-1:0]];
  assign dig      = xed_pkg::digit_value(cur, hex);
  assign cp_wide  = {4'h0, cp};
  assign acc      = (hex ? (cp_wide << 4) : ((cp_wide << 3) + (cp_wide << 1)))
                    + {32'd0, dig.val};
  assign cp_next  = (|acc[35:32]) ? 32'hFFFF_FFFF : acc[31:0];

  always_comb begin
    name_hit  = '0;
    name_byte = 8'h00;
    for (int n = 0; n < NN; n++) begin
      name_hit[n] = name_ok[n] && (q_len == CW'(xed_pkg::NAME_LEN[n]));
      if (name_hit[n]) name_byte = xed_pkg::NAME_CHAR[n];
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign load      = (state == B_IDLE) && q_valid;
  assign scan_step = (state == B_SCAN) && (idx != q_len);
  assign scan_done = (state == B_SCAN) && (idx == q_len);
  assign to_code   = (|name_hit) || (is_hash && q_len > CW'(1));
  assign body_end  = (idx + CW'(1)) == q_len;
  assign busy      = state != B_IDLE;

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = xed_pkg::CH_AMP;
    case (state)
      B_LEAD: begin
        emit      = out_free;
        emit_last = (q_len == '0) && !tail;
      end
      B_BODY: begin
        emit      = out_free;
        emit_byte = cur;
        emit_last = body_end && !tail;
      end
      B_TAIL: begin
        emit      = out_free;
        emit_byte = xed_pkg::CH_SEMI;
        emit_last = 1'b1;
      end
      B_CODE: begin
        emit      = out_free;
        emit_byte = code.bytes[idx[1:0]];
        emit_last = idx[1:0] == code.last_idx;
      end
      default: emit = 1'b0;
    endcase
  end

  assign q_pop = emit && emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            case (q_ctl.kind)
              xed_pkg::CMD_BYTE:   state <= B_CODE;
              xed_pkg::CMD_FLUSH:  state <= B_LEAD;
              xed_pkg::CMD_DECIDE: state <= B_SCAN;
              default:             state <= B_IDLE;
            endcase
          end
        end
        B_SCAN: begin
          if (scan_done) state <= to_code ? B_CODE : B_LEAD;
        end
        B_LEAD: begin
          if (emit) begin
            if (emit_last) state <= B_IDLE;
            else if (q_len == '0) state <= B_TAIL;
            else state <= B_BODY;
          end
        end
        B_BODY: begin
          if (emit && body_end) state <= tail ? B_TAIL : B_IDLE;
        end
        B_TAIL: begin
          if (emit) state <= B_IDLE;
        end
        B_CODE: begin
          if (emit && emit_last) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx           <= '0;
      tail          <= q_ctl.kind == xed_pkg::CMD_DECIDE;
      name_ok       <= '1;
      is_hash       <= 1'b0;
      hex           <= 1'b0;
      live          <= 1'b1;
      cp            <= 32'd0;
      code.bytes    <= {24'd0, q_ctl.data};
      code.last_idx <= 2'd0;
    end else if (scan_step) begin
      idx <= idx + CW'(1);
      for (int n = 0; n < NN; n++) begin
        name_ok[n] <= name_ok[n] && (idx < CW'(xed_pkg::NAME_LEN[n]))
                      && (cur == xed_pkg::NAME_STR[n][{idx[1:0], 3'b000} +: 8]);
      end
      if (idx == '0) begin
        is_hash <= cur == xed_pkg::CH_HASH;
      end else if (idx == CW'(1) && is_hash
                   && (cur == xed_pkg::CH_LX || cur == xed_pkg::CH_UX)) begin
        hex <= 1'b1;
      end else if (live) begin
        if (dig.ok) cp <= cp_next;
        else live <= 1'b0;
      end
    end else if (scan_done) begin
      idx <= '0;
      if (|name_hit) begin
        code.bytes    <= {24'd0, name_byte};
        code.last_idx <= 2'd0;
      end else begin
        code <= xed_pkg::utf8_encode(cp);
      end
    end else if (emit && (state == B_BODY || state == B_CODE)) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_byte;
      m_tuser <= emit_last;
      m_tlast <= emit_last && q_ctl.text_end;
    end
  end

endmodule

>>> tb/tb.sv
// Self-checking bench for xml_entity_decoder_utf8: byte stream in, decoded bytes out.
// Predicts each transaction's output bytes in-bench and scoreboards them in order.
// Depends on xed_pkg and the xml_entity_decoder_utf8 RTL.
module tb;

  localparam int SPAN        = 10;
  localparam int MAX_BEATS   = SPAN + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       text_done;
  } out_beat_t;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  xml_entity_decoder_utf8 #(.MAX_ENTITY_SPAN(SPAN)) dut (.*);

  // decoder shadow state
  logic       in_entity = 1'b0;
  logic [7:0] ent_buf [SPAN];
  int         ent_len = 0;

  out_beat_t  step_q[$];
  out_beat_t  decoded_q[$];
  logic [7:0] tok[$];

  int src_gap = 0;
  int dst_gap = 0;
  int bytes_sent = 0;
  int beats_checked = 0;
  int texts_done = 0;
  int mismatches = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, decoded_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= dst_gap);

  // ---------------------------------------------------------------- prediction
  function automatic void put_beat(logic [7:0] c);
    out_beat_t b;
    b.ch        = c;
    b.run_last  = 1'b0;
    b.text_done = 1'b0;
    if (step_q.size() < MAX_BEATS) step_q.insert(step_q.size(), b);
  endfunction

  function automatic bit name_is(string s);
    if (ent_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (ent_buf[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int digit_of(logic [7:0] c, logic hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void put_code_point(logic [31:0] cp);
    logic [31:0] lead;
    lead = 32'hF0 | (cp >> 18);
    if (cp < 32'h80) begin
      put_beat(cp[7:0]);
    end else if (cp < 32'h800) begin
      put_beat(8'hC0 | {3'b000, cp[10:6]});
      put_beat(8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 32'h10000) begin
      put_beat(8'hE0 | {4'h0, cp[15:12]});
      put_beat(8'h80 | {2'b00, cp[11:6]});
      put_beat(8'h80 | {2'b00, cp[5:0]});
    end else begin
      put_beat(lead[7:0]);
      put_beat(8'h80 | {2'b00, cp[17:12]});
      put_beat(8'h80 | {2'b00, cp[11:6]});
      put_beat(8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void close_entity();
    logic        hex;
    logic [63:0] cp;
    logic [63:0] base;
    int          d;
    if (name_is("amp")) put_beat(xed_pkg::CH_AMP);
    else if (name_is("lt")) put_beat("<");
    else if (name_is("gt")) put_beat(">");
    else if (name_is("quot")) put_beat("\"");
    else if (name_is("apos")) put_beat("'");
    else if (ent_len > 1 && ent_buf[0] == xed_pkg::CH_HASH) begin
      hex  = (ent_buf[1] == xed_pkg::CH_LX) || (ent_buf[1] == xed_pkg::CH_UX);
      base = hex ? 64'd16 : 64'd10;
      cp   = 64'd0;
      for (int i = hex ? 2 : 1; i < ent_len; i++) begin
        d = digit_of(ent_buf[i], hex);
        if (d < 0) break;
        cp = cp * base + d;
        if (cp > 64'hFFFF_FFFF) cp = 64'hFFFF_FFFF;
      end
      if (cp != 64'd0) put_code_point(cp[31:0]);
      else put_beat(xed_pkg::CH_QMARK);
    end else begin
      put_beat(xed_pkg::CH_AMP);
      for (int i = 0; i < ent_len; i++) put_beat(ent_buf[i]);
      put_beat(xed_pkg::CH_SEMI);
    end
  endfunction

  // no ';' in time: '&' out, bytes up to an inner '&' out, rest reopens an entity
  function automatic void replay_entity();
    int k;
    int rest;
    k = ent_len;
    put_beat(xed_pkg::CH_AMP);
    for (int i = 0; i < ent_len; i++) begin
      if (ent_buf[i] == xed_pkg::CH_AMP) begin
        k = i;
        break;
      end
      put_beat(ent_buf[i]);
    end
    if (k < ent_len) begin
      rest = ent_len - k - 1;
      for (int j = 0; j < rest; j++) ent_buf[j] = ent_buf[k + 1 + j];
      ent_len   = rest;
      in_entity = 1'b1;
    end else begin
      ent_len   = 0;
      in_entity = 1'b0;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    out_beat_t tail;
    int        n;
    step_q.delete();
    if (!in_entity) begin
      if (b == xed_pkg::CH_AMP) begin
        in_entity = 1'b1;
        ent_len   = 0;
      end else begin
        put_beat(b);
      end
    end else if (b == xed_pkg::CH_SEMI) begin
      close_entity();
      in_entity = 1'b0;
      ent_len   = 0;
    end else if (ent_len + 1 < SPAN) begin
      ent_buf[ent_len] = b;
      ent_len++;
    end else begin
      if (ent_len < SPAN) begin
        ent_buf[ent_len] = b;
        ent_len++;
      end
      replay_entity();
    end
    if (last && in_entity) begin
      put_beat(xed_pkg::CH_AMP);
      for (int i = 0; i < ent_len; i++) put_beat(ent_buf[i]);
      in_entity = 1'b0;
      ent_len   = 0;
    end
    n = step_q.size();
    if (n > 0) begin
      tail           = step_q[n - 1];
      tail.run_last  = 1'b1;
      tail.text_done = last;
      step_q[n - 1]  = tail;
      for (int i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), step_q[i]);
    end
  endfunction

  // ---------------------------------------------------------------- checking
  out_beat_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_checked++;
      if (m_tlast) texts_done++;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected output byte %h (run_last %b text_done %b)",
                 $time, m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (m_tdata !== want.ch) begin
          $display("%0t: out_byte expected %h got %h", $time, want.ch, m_tdata);
          mismatches++;
        end
        if (m_tuser !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time, want.run_last, m_tuser);
          mismatches++;
        end
        if (m_tlast !== want.text_done) begin
          $display("%0t: text_done expected %b got %b", $time, want.text_done, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_gap) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(255));
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) tok.insert(tok.size(), s[i]);
  endfunction

  task automatic send_tok(input bit end_flag);
    int n;
    n = tok.size();
    for (int i = 0; i < n; i++) send_byte(tok[i], end_flag && (i == n - 1));
    tok.delete();
  endtask

  function automatic logic [7:0] content_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == xed_pkg::CH_SEMI || c == xed_pkg::CH_AMP) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
  endfunction

  function automatic string entity_name(int idx);
    case (idx)
      0: return "amp";
      1: return "lt";
      2: return "gt";
      3: return "quot";
      default: return "apos";
    endcase
  endfunction

  task automatic test_plain_bytes();
    tok.insert(tok.size(), 8'h00);
    tok.insert(tok.size(), 8'hFF);
    tok.insert(tok.size(), xed_pkg::CH_SEMI);
    send_tok(1'b1);
  endtask

  task automatic test_named_entities();
    add_str("&amp;&lt;&gt;&quot;&apos;");
    send_tok(1'b0);
  endtask

  task automatic test_numeric_entities();
    add_str("&#65;&#x3a9;&#X20AC;&#x1F600;&#xFFFFFFF;&#99999999;");
    add_str("&#0;&#-5;&# 7;&#0x12;&#x;");
    send_tok(1'b0);
  endtask

  task automatic test_literal_entities();
    add_str("&#;&;&foo;&AMP;");
    send_tok(1'b0);
  endtask

  task automatic test_timeouts();
    add_str("&abcdefghijk");
    add_str("&ab&cdefghij;");
    add_str("&&&&&&&&&&&x;");
    send_tok(1'b0);
  endtask

  task automatic test_end_of_text();
    add_str("&");
    send_tok(1'b1);
    add_str("&quo");
    send_tok(1'b1);
    add_str("&#x4&");
    send_tok(1'b1);
    add_str("&lt;");
    send_tok(1'b1);
  endtask

  task automatic test_random_text(input int n_bytes);
    int start;
    int pick;
    int len;
    int idx;
    string nm;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        tok.insert(tok.size(), 8'($urandom_range(255)));
      end else if (pick < 50) begin
        nm = entity_name($urandom_range(4));
        add_str("&");
        add_str(nm);
        if ($urandom_range(4) == 0) tok[$urandom_range(nm.len())] = content_byte();
        add_str(";");
      end else if (pick < 62) begin
        add_str("&#");
        len = $urandom_range(8, 1);
        if ($urandom_range(6) == 0) begin
          case ($urandom_range(2))
            0: add_str(" ");
            1: add_str("+");
            default: add_str("-");
          endcase
          len = len > 7 ? 7 : len;
        end
        for (int i = 0; i < len; i++) tok.insert(tok.size(), 8'("0" + $urandom_range(9)));
        add_str(";");
      end else if (pick < 74) begin
        add_str($urandom_range(1) ? "&#x" : "&#X");
        len = $urandom_range(7, 1);
        for (int i = 0; i < len; i++) tok.insert(tok.size(), hex_char($urandom_range(15)));
        if (len < 7 && $urandom_range(5) == 0) add_str("g");
        add_str(";");
      end else if (pick < 84) begin
        add_str("&");
        len = $urandom_range(9);
        for (int i = 0; i < len; i++) tok.insert(tok.size(), content_byte());
        add_str(";");
      end else if (pick < 92) begin
        add_str("&");
        len = $urandom_range(14, 10);
        for (int i = 0; i < len; i++)
          tok.insert(tok.size(),
                     $urandom_range(6) == 0 ? xed_pkg::CH_AMP : content_byte());
      end else begin
        add_str("&");
        len = $urandom_range(8);
        for (int i = 0; i < len; i++) tok.insert(tok.size(), content_byte());
        send_tok(1'b1);
      end
      idx = $urandom_range(19);
      send_tok(idx == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_gap = 30;
    dst_gap = 78;
    test_plain_bytes();
    test_named_entities();
    test_numeric_entities();
    test_literal_entities();
    test_timeouts();
    test_end_of_text();
    test_random_text(110);

    src_gap = 78;
    dst_gap = 30;
    test_random_text(110);

    src_gap = 0;
    dst_gap = 0;
    test_random_text(110);

    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d text bytes (named, numeric, literal, timed-out and cut-off entities)",
             bytes_sent);
    $display("checked %0d decoded bytes over %0d finished texts, %0d mismatches",
             beats_checked, texts_done, mismatches);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
